>>> rtl/mwrms_pkg.sv
// Shared types and constants of the multichannel windowed RMS meter.
`timescale 1ns / 1ps

package mwrms_pkg;

    localparam int NUM_FIELDS = 8;
    localparam int CH_W       = 3;
    localparam int SAMPLE_W   = 8;
    localparam int SQUARE_W   = 16;
    localparam int SUM_W      = 25;
    localparam int COUNT_W    = 10;
    localparam int RMS_W      = 16;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [COUNT_W-1:0] WINDOW_RESET = 10'd300;
    localparam logic [COUNT_W-1:0] COUNT_RESET  = 10'd1;
    localparam logic [RMS_W-1:0]   RMS_MAX      = 16'hFFFF;

    localparam logic REG_WINDOW = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_CHECK,
        ST_DIVINIT,
        ST_DIV,
        ST_SQINIT,
        ST_SQRT,
        ST_STORE_LOAD
    } state_t;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

endpackage

>>> rtl/mwrms_if.sv
// Handshake interfaces for sample snapshot beats and RMS result beats.
`timescale 1ns / 1ps

interface mwrms_in_if;
    import mwrms_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_ch0;
    logic signed [SAMPLE_W-1:0] sample_ch1;
    logic signed [SAMPLE_W-1:0] sample_ch2;
    logic signed [SAMPLE_W-1:0] sample_ch3;
    logic signed [SAMPLE_W-1:0] sample_ch4;
    logic signed [SAMPLE_W-1:0] sample_ch5;
    logic signed [SAMPLE_W-1:0] sample_ch6;
    logic signed [SAMPLE_W-1:0] sample_ch7;

    modport source (
        output valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
               sample_ch4, sample_ch5, sample_ch6, sample_ch7,
        input  ready
    );

    modport sink (
        input  valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
               sample_ch4, sample_ch5, sample_ch6, sample_ch7,
        output ready
    );
endinterface

interface mwrms_out_if;
    import mwrms_pkg::*;

    logic             valid;
    logic             ready;
    logic [RMS_W-1:0] rms_ch0;
    logic [RMS_W-1:0] rms_ch1;
    logic [RMS_W-1:0] rms_ch2;
    logic [RMS_W-1:0] rms_ch3;
    logic [RMS_W-1:0] rms_ch4;
    logic [RMS_W-1:0] rms_ch5;
    logic [RMS_W-1:0] rms_ch6;
    logic [RMS_W-1:0] rms_ch7;

    modport source (
        output valid, rms_ch0, rms_ch1, rms_ch2, rms_ch3,
               rms_ch4, rms_ch5, rms_ch6, rms_ch7,
        input  ready
    );

    modport sink (
        input  valid, rms_ch0, rms_ch1, rms_ch2, rms_ch3,
               rms_ch4, rms_ch5, rms_ch6, rms_ch7,
        output ready
    );
endinterface

>>> rtl/multichannel_windowed_rms.sv
// Top level of the eight-channel block RMS meter with a shared add/subtract unit.
`timescale 1ns / 1ps
//
// The samples channel takes one beat holding a signed snapshot of eight
// channels. Each beat is accumulated into per-channel sums of squares, one
// channel per cycle through the shared adder, and a check state then decides
// whether the window is closed; if not, the block is ready again.
// When the snapshot count reaches window_length, every channel is divided by
// the window with a restoring divider and then square-rooted two bits per step,
// both on the same add/subtract unit.
// The result beat sits in an output register on the results channel; the next
// snapshot is accepted while it waits. A finished result only waits for the
// output register when the previous result has not been taken yet.
// window_length is set over APB; the user must write it only while the block
// is idle, which the block does not enforce; zero acts as one. Reset clears
// the sums, sets the count to one and the window to 300, and drops out_valid.
//
module multichannel_windowed_rms #(
    parameter int CHANNELS  = 8,
    parameter int FRAC_BITS = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    mwrms_in_if.sink                            samples,
    mwrms_out_if.source                         results,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mwrms_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [mwrms_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [mwrms_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready
);
    import mwrms_pkg::*;

    localparam int DIV_W  = SUM_W + 2 * FRAC_BITS;
    localparam int SQ_W   = ((DIV_W + 1) / 2) * 2;
    localparam int RT_W   = SQ_W / 2;
    localparam int ALU_W  = (RT_W + 2 > SUM_W) ? RT_W + 2 : SUM_W;
    localparam int RX_W   = (RT_W > RMS_W) ? RT_W : RMS_W;
    localparam int STEP_W = $clog2(DIV_W);
    localparam logic [CH_W-1:0] CH_LAST = CH_W'(CHANNELS - 1);

    state_t                      state_reg, state_next;
    logic [CH_W-1:0]             ch_reg, ch_next;
    logic [STEP_W-1:0]           step_reg, step_next;
    logic [COUNT_W-1:0]          count_reg, count_next;
    logic [COUNT_W-1:0]          window_reg;
    logic                        out_valid_reg, out_valid_next;
    logic [SUM_W-1:0]            sum_reg [NUM_FIELDS];
    logic [SUM_W-1:0]            sum_next [NUM_FIELDS];

    logic signed [SAMPLE_W-1:0]  smp_in [NUM_FIELDS];
    logic signed [SAMPLE_W-1:0]  smp_reg [NUM_FIELDS];
    logic [DIV_W-1:0]            quo_reg, quo_next;
    logic [COUNT_W-1:0]          rem_reg, rem_next;
    logic [SQ_W-1:0]             rad_reg, rad_next;
    logic [RT_W+1:0]             srem_reg, srem_next;
    logic [RT_W-1:0]             root_reg, root_next;
    logic [RMS_W-1:0]            res_reg [NUM_FIELDS];
    logic [RMS_W-1:0]            res_next [NUM_FIELDS];
    logic [RMS_W-1:0]            out_rms_reg [NUM_FIELDS];
    logic [RMS_W-1:0]            out_rms_next [NUM_FIELDS];

    logic                        in_accept;
    logic                        out_take;
    logic                        out_free;
    logic                        cfg_write;
    logic [COUNT_W-1:0]          win_eff;
    logic                        window_done;
    logic [SAMPLE_W-1:0]         mag;
    logic [SQUARE_W-1:0]         square;
    logic [COUNT_W:0]            div_trial;
    logic [RT_W+1:0]             sq_shift;
    logic [RT_W+1:0]             sq_trial;
    logic [RX_W-1:0]             root_ext;
    logic [RMS_W-1:0]            root_sat;

    alu_op_t                     alu_op;
    logic [ALU_W-1:0]            alu_a;
    logic [ALU_W-1:0]            alu_b;
    logic [ALU_W:0]              alu_res;
    logic                        alu_ge;

    assign smp_in[0] = samples.sample_ch0;
    assign smp_in[1] = samples.sample_ch1;
    assign smp_in[2] = samples.sample_ch2;
    assign smp_in[3] = samples.sample_ch3;
    assign smp_in[4] = samples.sample_ch4;
    assign smp_in[5] = samples.sample_ch5;
    assign smp_in[6] = samples.sample_ch6;
    assign smp_in[7] = samples.sample_ch7;

    assign samples.ready = (state_reg == ST_IDLE);
    assign in_accept     = samples.valid && samples.ready;
    assign out_take      = out_valid_reg && results.ready;
    assign out_free      = !out_valid_reg || results.ready;

    assign results.valid   = out_valid_reg;
    assign results.rms_ch0 = out_rms_reg[0];
    assign results.rms_ch1 = out_rms_reg[1];
    assign results.rms_ch2 = out_rms_reg[2];
    assign results.rms_ch3 = out_rms_reg[3];
    assign results.rms_ch4 = out_rms_reg[4];
    assign results.rms_ch5 = out_rms_reg[5];
    assign results.rms_ch6 = out_rms_reg[6];
    assign results.rms_ch7 = out_rms_reg[7];

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[APB_ADDR_W-1] == REG_WINDOW);
    assign prdata    = (paddr[APB_ADDR_W-1] == REG_WINDOW) ? APB_DATA_W'(window_reg) : '0;

    assign win_eff     = (window_reg == '0) ? COUNT_W'(1) : window_reg;
    assign window_done = (count_reg == win_eff);

    assign mag    = smp_reg[ch_reg][SAMPLE_W-1] ? SAMPLE_W'(-smp_reg[ch_reg])
                                                : SAMPLE_W'(smp_reg[ch_reg]);
    assign square = SQUARE_W'(mag) * SQUARE_W'(mag);

    assign div_trial = {rem_reg, quo_reg[DIV_W-1]};
    assign sq_shift  = {srem_reg[RT_W-1:0], rad_reg[SQ_W-1:SQ_W-2]};
    assign sq_trial  = {root_reg, 2'b01};

    assign root_ext = RX_W'(root_reg);
    assign root_sat = (root_ext > RX_W'(RMS_MAX)) ? RMS_MAX : root_ext[RMS_W-1:0];

    assign alu_res = (alu_op == ALU_ADD) ? ({1'b0, alu_a} + {1'b0, alu_b})
                                         : ({1'b0, alu_a} - {1'b0, alu_b});
    assign alu_ge  = !alu_res[ALU_W];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                    state_next = ST_ACC;
            end
            ST_ACC:
            begin
                if (ch_reg == CH_LAST)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                state_next = window_done ? ST_DIVINIT : ST_IDLE;
            end
            ST_DIVINIT:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (step_reg == '0)
                    state_next = ST_SQINIT;
            end
            ST_SQINIT:
            begin
                state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                if (step_reg == '0)
                    state_next = (ch_reg == CH_LAST) ? ST_STORE_LOAD : ST_DIVINIT;
            end
            ST_STORE_LOAD:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ch_next        = ch_reg;
        step_next      = step_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !out_take;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        rad_next       = rad_reg;
        srem_next      = srem_reg;
        root_next      = root_reg;
        alu_op         = ALU_ADD;
        alu_a          = '0;
        alu_b          = '0;
        for (int i = 0; i < NUM_FIELDS; i++)
        begin
            sum_next[i]     = sum_reg[i];
            res_next[i]     = res_reg[i];
            out_rms_next[i] = out_rms_reg[i];
        end

        case (state_reg)
            ST_IDLE:
            begin
                ch_next = '0;
            end
            ST_ACC:
            begin
                alu_op           = ALU_ADD;
                alu_a            = ALU_W'(sum_reg[ch_reg]);
                alu_b            = ALU_W'(square);
                sum_next[ch_reg] = alu_res[SUM_W-1:0];
                if (ch_reg != CH_LAST)
                    ch_next = ch_reg + 1'b1;
            end
            ST_CHECK:
            begin
                ch_next    = '0;
                count_next = window_done ? COUNT_RESET : count_reg + 1'b1;
            end
            ST_DIVINIT:
            begin
                quo_next         = DIV_W'(sum_reg[ch_reg]) << (2 * FRAC_BITS);
                rem_next         = '0;
                step_next        = STEP_W'(DIV_W - 1);
                sum_next[ch_reg] = '0;
            end
            ST_DIV:
            begin
                alu_op    = ALU_SUB;
                alu_a     = ALU_W'(div_trial);
                alu_b     = ALU_W'(win_eff);
                rem_next  = alu_ge ? alu_res[COUNT_W-1:0] : div_trial[COUNT_W-1:0];
                quo_next  = {quo_reg[DIV_W-2:0], alu_ge};
                step_next = step_reg - 1'b1;
            end
            ST_SQINIT:
            begin
                rad_next  = SQ_W'(quo_reg);
                srem_next = '0;
                root_next = '0;
                step_next = STEP_W'(RT_W - 1);
            end
            ST_SQRT:
            begin
                alu_op    = ALU_SUB;
                alu_a     = ALU_W'(sq_shift);
                alu_b     = ALU_W'(sq_trial);
                srem_next = alu_ge ? alu_res[RT_W+1:0] : sq_shift;
                root_next = {root_reg[RT_W-2:0], alu_ge};
                rad_next  = rad_reg << 2;
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                    ch_next = ch_reg + 1'b1;
            end
            ST_STORE_LOAD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    for (int i = 0; i < NUM_FIELDS; i++)
                        out_rms_next[i] = (i < CHANNELS) ? res_reg[i] : '0;
                end
            end
            default:
            begin
                ch_next = '0;
            end
        endcase

        // The root of the last step only exists after that step's edge, so the
        // saturated value is captured from root_reg in the following state.
        if (state_reg == ST_DIVINIT && ch_reg != '0)
            res_next[ch_reg - 1'b1] = root_sat;
        if (state_reg == ST_STORE_LOAD && ch_reg == CH_LAST)
            res_next[ch_reg] = root_sat;
        if (state_reg == ST_STORE_LOAD && out_free)
            for (int i = 0; i < NUM_FIELDS; i++)
                if (i == int'(CH_LAST))
                    out_rms_next[i] = root_sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ch_reg        <= '0;
            step_reg      <= '0;
            count_reg     <= COUNT_RESET;
            window_reg    <= WINDOW_RESET;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_FIELDS; i++)
                sum_reg[i] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            ch_reg        <= ch_next;
            step_reg      <= step_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < NUM_FIELDS; i++)
                sum_reg[i] <= sum_next[i];
            if (cfg_write)
                window_reg <= pwdata[COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            for (int i = 0; i < NUM_FIELDS; i++)
                smp_reg[i] <= smp_in[i];
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        rad_reg  <= rad_next;
        srem_reg <= srem_next;
        root_reg <= root_next;
        for (int i = 0; i < NUM_FIELDS; i++)
        begin
            res_reg[i]     <= res_next[i];
            out_rms_reg[i] <= out_rms_next[i];
        end
    end

endmodule

>>> rtl/mwrms_checker.sv
// Port-level assertions for the RMS meter and the bind that attaches them.
`timescale 1ns / 1ps

module mwrms_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic [mwrms_pkg::RMS_W-1:0]         rms_ch0,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mwrms_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [mwrms_pkg::APB_DATA_W-1:0]    pwdata,
    input  logic [mwrms_pkg::APB_DATA_W-1:0]    prdata
);
    import mwrms_pkg::*;

    // A result beat that is not taken stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(rms_ch0))
        else $error("result beat dropped or changed while stalled");

    // The block is busy in the cycle after every snapshot beat.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("snapshot accepted while the previous one was in work");

    // A new result only shows up when the input side was held off just before.
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without a finished computation");

    // A window write reads back on the next cycle.
    a_window_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && (paddr[APB_ADDR_W-1] == REG_WINDOW)
        |=> (paddr[APB_ADDR_W-1] != REG_WINDOW)
            || (prdata[COUNT_W-1:0] == $past(pwdata[COUNT_W-1:0])))
        else $error("window register did not take the written value");

endmodule

bind multichannel_windowed_rms mwrms_checker u_mwrms_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .rms_ch0   (results.rms_ch0),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata)
);
